// ===== src/rccm_pkg.sv =====
// Shared types, constants and helper functions of the character class matcher.
`default_nettype none

package rccm_pkg;

	// Configuration port geometry
	localparam int MAX_RANGES       = 4;
	localparam int RANGE_W          = 16;
	localparam int CFG_DATA_W       = 64;
	localparam int CFG_IDX_W        = 3;
	localparam int RANGE_ENTRIES_DEF = MAX_RANGES;
	localparam int CLASS_W          = 6;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_TABLE  = 3'd0,
		REG_RANGE_ENABLE = 3'd1,
		REG_CLASS_MASK   = 3'd2,
		REG_INVERT       = 3'd3,
		REG_CASE_FOLD    = 3'd4
	} cfg_reg_t;

	// Bit positions in the shorthand class mask
	localparam int CLS_DIGIT    = 0;
	localparam int CLS_NONDIGIT = 1;
	localparam int CLS_WORD     = 2;
	localparam int CLS_NONWORD  = 3;
	localparam int CLS_SPACE    = 4;
	localparam int CLS_NONSPACE = 5;

	// Character constants
	localparam logic [7:0] CHAR_ZERO       = 8'h30;
	localparam logic [7:0] CHAR_NINE       = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_SPACE      = 8'h20;
	localparam logic [7:0] FOLD_MASK       = 8'h20;

	// Bound compares of one range entry, plain and case folded
	typedef struct packed {
		logic in_lo;    // low <= char
		logic in_hi;    // char <= high
		logic fold_ok;  // folding on and both ends are letters
		logic fin_lo;   // folded low <= char
		logic fin_hi;   // char <= folded high
	} range_cmp_t;

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
			((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

endpackage

`default_nettype wire

// ===== src/regex_char_class_matcher.sv =====
// Regex bracket class matcher: three stage pipeline, one byte per cycle while the output is not stalled.
// An input transfer passes through stage 1, stage 2 and stage 3 before its result shows on m_tdata.
// Throughput: one byte per cycle; each stage holds when the one after it is full and stalled.
// Stage 1 registers the byte, stage 2 the range compares and shorthand predicates, stage 3 the class result.
// Reset (arst_n low, asynchronous) empties the pipeline and clears every class register.
`default_nettype none

module regex_char_class_matcher
	import rccm_pkg::*;
#(
	parameter int RANGE_ENTRIES = RANGE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input byte stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] char_in
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata    // [0] matched, [7:1] zero
);

	localparam int TABLE_W = RANGE_ENTRIES * RANGE_W;

	// Class registers
	logic [TABLE_W-1:0]       range_table_q;
	logic [RANGE_ENTRIES-1:0] range_enable_q;
	logic [CLASS_W-1:0]       class_mask_q;
	logic                     invert_q;
	logic                     case_fold_q;

	// Pipeline registers
	logic                     v_s1, v_s2, v_s3;
	logic [7:0]               char_s1;
	range_cmp_t               cmp_s2 [RANGE_ENTRIES];
	logic                     digit_s2, word_s2, space_s2;
	logic                     matched_s3;

	logic                     rdy_s1, rdy_s2, rdy_s3;
	range_cmp_t               cmp_w [RANGE_ENTRIES];
	logic                     hit;

	// Write class registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_table_q  <= '0;
			range_enable_q <= '0;
			class_mask_q   <= '0;
			invert_q       <= 1'b0;
			case_fold_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_RANGE_TABLE:  range_table_q  <= cfg_data[TABLE_W-1:0];
				REG_RANGE_ENABLE: range_enable_q <= cfg_data[RANGE_ENTRIES-1:0];
				REG_CLASS_MASK:   class_mask_q   <= cfg_data[CLASS_W-1:0];
				REG_INVERT:       invert_q       <= cfg_data[0];
				REG_CASE_FOLD:    case_fold_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Each stage takes new data when empty or when its contents move on
	assign rdy_s3   = !v_s3 || m_tready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// Stage 1: hold the byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	// Stage 2: range bound compares and shorthand predicates
	for (genvar g = 0; g < RANGE_ENTRIES; g++) begin : g_range
		rccm_range_cmp u_cmp (
			.lo   (range_table_q[g*RANGE_W +: 8]),
			.hi   (range_table_q[g*RANGE_W + 8 +: 8]),
			.ch   (char_s1),
			.fold (case_fold_q),
			.cmp  (cmp_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			cmp_s2   <= cmp_w;
			digit_s2 <= is_digit(char_s1);
			word_s2  <= is_letter(char_s1) || is_digit(char_s1) ||
				(char_s1 == CHAR_UNDERSCORE);
			space_s2 <= (char_s1 == CHAR_SPACE);
		end
	end

	// Stage 3: OR of enabled members, then apply negation
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < RANGE_ENTRIES; i++) begin
			if (range_enable_q[i] &&
				((cmp_s2[i].in_lo && cmp_s2[i].in_hi) ||
				 (cmp_s2[i].fold_ok && cmp_s2[i].fin_lo && cmp_s2[i].fin_hi))) begin
				hit = 1'b1;
			end
		end
		if (class_mask_q[CLS_DIGIT]    &&  digit_s2) hit = 1'b1;
		if (class_mask_q[CLS_NONDIGIT] && !digit_s2) hit = 1'b1;
		if (class_mask_q[CLS_WORD]     &&  word_s2)  hit = 1'b1;
		if (class_mask_q[CLS_NONWORD]  && !word_s2)  hit = 1'b1;
		if (class_mask_q[CLS_SPACE]    &&  space_s2) hit = 1'b1;
		if (class_mask_q[CLS_NONSPACE] && !space_s2) hit = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			matched_s3 <= hit ^ invert_q;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {7'd0, matched_s3};

	// An empty pipeline always takes a byte
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !v_s2 && !v_s3) |-> s_tready)
		else $error("empty pipeline refused a byte");

	// A stalled result is never dropped
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !m_tready) |=> v_s3)
		else $error("stalled result lost");

	// An empty, non-negated class never matches
	a_empty_class: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (range_enable_q == '0) && (class_mask_q == '0) && !invert_q)
		|-> !m_tdata[0])
		else $error("empty class reported a match");

endmodule

`default_nettype wire

// ===== src/rccm_range_cmp.sv =====
// Bound compares of one range entry against one character, with case folding.
`default_nettype none

module rccm_range_cmp
	import rccm_pkg::*;
(
	input  logic [7:0] lo,
	input  logic [7:0] hi,
	input  logic [7:0] ch,
	input  logic       fold,
	output range_cmp_t cmp
);

	logic [7:0] flo;
	logic [7:0] fhi;

	// Flip bit 5 of both ends for the other letter case
	assign flo = lo ^ FOLD_MASK;
	assign fhi = hi ^ FOLD_MASK;

	assign cmp.in_lo   = (lo <= ch);
	assign cmp.in_hi   = (ch <= hi);
	assign cmp.fold_ok = fold && is_letter(lo) && is_letter(hi);
	assign cmp.fin_lo  = (flo <= ch);
	assign cmp.fin_hi  = (ch <= fhi);

endmodule

`default_nettype wire
